[hw/rtl/u2c_pkg.sv]
// Constants, the CP437 upper-half table and decode helpers for the UTF-8 to CP437 decoder.
// No dependencies.
package u2c_pkg;

  localparam logic [7:0] QMARK      = 8'h3F;
  localparam int         FIFO_DEPTH = 8;
  localparam int         MAX_RES    = 3;

  // Unicode code point for CP437 bytes 0x80..0xFF
  localparam logic [15:0] HI_HALF [0:127] = '{
    16'h00C7, 16'h00FC, 16'h00E9, 16'h00E2, 16'h00E4, 16'h00E0, 16'h00E5, 16'h00E7,
    16'h00EA, 16'h00EB, 16'h00E8, 16'h00EF, 16'h00EE, 16'h00EC, 16'h00C4, 16'h00C5,
    16'h00C9, 16'h00E6, 16'h00C6, 16'h00F4, 16'h00F6, 16'h00F2, 16'h00FB, 16'h00F9,
    16'h00FF, 16'h00D6, 16'h00DC, 16'h00A2, 16'h00A3, 16'h00A5, 16'h20A7, 16'h0192,
    16'h00E1, 16'h00ED, 16'h00F3, 16'h00FA, 16'h00F1, 16'h00D1, 16'h00AA, 16'h00BA,
    16'h00BF, 16'h2310, 16'h00AC, 16'h00BD, 16'h00BC, 16'h00A1, 16'h00AB, 16'h00BB,
    16'h2591, 16'h2592, 16'h2593, 16'h2502, 16'h2524, 16'h2561, 16'h2562, 16'h2556,
    16'h2555, 16'h2563, 16'h2551, 16'h2557, 16'h255D, 16'h255C, 16'h255B, 16'h2510,
    16'h2514, 16'h2534, 16'h252C, 16'h251C, 16'h2500, 16'h253C, 16'h255E, 16'h255F,
    16'h255A, 16'h2554, 16'h2569, 16'h2566, 16'h2560, 16'h2550, 16'h256C, 16'h2567,
    16'h2568, 16'h2564, 16'h2565, 16'h2559, 16'h2558, 16'h2552, 16'h2553, 16'h256B,
    16'h256A, 16'h2518, 16'h250C, 16'h2588, 16'h2584, 16'h258C, 16'h2590, 16'h2580,
    16'h03B1, 16'h00DF, 16'h0393, 16'h03C0, 16'h03A3, 16'h03C3, 16'h00B5, 16'h03C4,
    16'h03A6, 16'h0398, 16'h03A9, 16'h03B4, 16'h221E, 16'h03C6, 16'h03B5, 16'h2229,
    16'h2261, 16'h00B1, 16'h2265, 16'h2264, 16'h2320, 16'h2321, 16'h00F7, 16'h2248,
    16'h00B0, 16'h2219, 16'h00B7, 16'h221A, 16'h207F, 16'h00B2, 16'h25A0, 16'h00A0
  };

  // sequence length from a lead byte, 0 for a stray or invalid lead
  function automatic logic [2:0] seq_len(input logic [7:0] b);
    logic [2:0] len;
    if (!b[7])                    len = 3'd1;
    else if (b[7:5] == 3'b110)    len = 3'd2;
    else if (b[7:4] == 4'b1110)   len = 3'd3;
    else if (b[7:3] == 5'b11110)  len = 3'd4;
    else                          len = 3'd0;
    return len;
  endfunction

  function automatic logic [20:0] code_point(input logic [7:0] b0, input logic [7:0] b1,
                                             input logic [7:0] b2, input logic [7:0] b3,
                                             input logic [2:0] len);
    logic [20:0] cp;
    case (len)
      3'd2:    cp = {10'd0, b0[4:0], b1[5:0]};
      3'd3:    cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
      3'd4:    cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
      default: cp = {13'd0, b0};
    endcase
    return cp;
  endfunction

  // reverse table lookup; entries are unique so the matches are simply ORed
  function automatic logic [7:0] cp437_map(input logic [20:0] cp);
    logic [7:0] r;
    logic       hit;
    r   = 8'd0;
    hit = 1'b0;
    if (cp < 21'h80) begin
      r   = cp[7:0];
      hit = 1'b1;
    end else begin
      for (int k = 0; k < 128; k++) begin
        if (cp == {5'd0, HI_HALF[k]}) begin
          r   = r | {1'b1, 7'(k)};
          hit = 1'b1;
        end
      end
    end
    return hit ? r : QMARK;
  endfunction

endpackage

[hw/rtl/utf8_to_cp437_decoder.sv]
// UTF-8 byte stream to code page 437 decoder, top level.
// Depends on u2c_pkg (table, decode helpers, constants).
//
//   channel   dir  tdata                tlast
//   s_*       in   [7:0] in_byte        end_of_buffer
//   m_*       out  [7:0] cp437_byte     run_last
//
// One byte is taken per cycle while s_tready is high. A byte is registered, decoded in the
// next cycle and its 0..3 result bytes are pushed into an 8-entry result FIFO, one drained
// per cycle while m_tready is high. Results go from the input register through the FIFO to m_*.
// s_tready depends only on registers (FIFO fill and the input register's valid bit): it
// drops while fewer than three free slots would remain after reserving three for an item
// already in flight. Synchronous reset empties the FIFO and drops any partial sequence.
module utf8_to_cp437_decoder
  import u2c_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tlast,   // end_of_buffer
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] cp437_byte
  output logic       m_tlast    // run_last
);

  localparam int PW = $clog2(FIFO_DEPTH);

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_eob;

  // partial sequence
  logic [7:0] held [0:2];
  logic [1:0] held_count;

  // decode
  logic [7:0] bufb [0:3];
  logic [2:0] tot;
  logic [2:0] step_pos;
  logic [2:0] step_len;
  logic       step_fit;
  logic [7:0] res_byte [0:MAX_RES-1];
  logic [1:0] all_n;
  logic [1:0] res_n;
  logic [2:0] len0;
  logic       hold;

  // result FIFO
  logic [8:0]  mem [0:FIFO_DEPTH-1];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;
  logic [PW:0]   count_next;
  logic [PW:0]   committed;
  logic [1:0]    push_n;
  logic          pop;

  always_comb begin
    committed = count + (in_valid ? (PW+1)'(MAX_RES) : '0);
    s_tready  = committed <= (PW+1)'(FIFO_DEPTH - MAX_RES);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= s_tvalid && s_tready;
    end
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_eob  <= s_tlast;
    end
  end

  always_comb begin
    bufb[0] = (held_count > 2'd0) ? held[0] : in_byte;
    bufb[1] = (held_count > 2'd1) ? held[1] : in_byte;
    bufb[2] = (held_count > 2'd2) ? held[2] : in_byte;
    bufb[3] = in_byte;
    tot     = {1'b0, held_count} + 3'd1;

    // walk the buffer left to right; at end of buffer each position acts as a lead
    step_pos = 3'd0;
    step_len = 3'd0;
    step_fit = 1'b0;
    all_n    = 2'd0;
    for (int s = 0; s < MAX_RES; s++) begin
      res_byte[s] = QMARK;
      if (step_pos < tot) begin
        step_len = seq_len(bufb[step_pos[1:0]]);
        step_fit = (step_len >= 3'd2) && (step_pos + step_len <= tot);
        if (step_len == 3'd1) begin
          res_byte[s] = bufb[step_pos[1:0]];
        end else if (step_fit) begin
          res_byte[s] = cp437_map(code_point(bufb[step_pos[1:0]],
                                             bufb[step_pos[1:0] + 2'd1],
                                             bufb[step_pos[1:0] + 2'd2],
                                             bufb[step_pos[1:0] + 2'd3],
                                             step_len));
        end
        step_pos = step_pos + (step_fit ? step_len : 3'd1);
        all_n    = 2'(s + 1);
      end
    end

    len0 = seq_len(bufb[0]);
    hold = !in_eob && (len0 != 3'd0) && (tot < len0);
    if (!in_valid || hold) begin
      res_n = 2'd0;
    end else if (in_eob) begin
      res_n = all_n;
    end else begin
      res_n = 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= 2'd0;
    end else if (in_valid) begin
      held_count <= hold ? tot[1:0] : 2'd0;
    end
    if (in_valid && hold) begin
      held[held_count] <= in_byte;
    end
  end

  always_comb begin
    push_n     = res_n;
    pop        = m_tvalid && m_tready;
    count_next = count + (PW+1)'(push_n) - (PW+1)'(pop);
    m_tvalid   = count != '0;
    m_tdata    = mem[rd_ptr][7:0];
    m_tlast    = mem[rd_ptr][8];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(push_n);
      rd_ptr <= rd_ptr + PW'(pop);
      count  <= count_next;
    end
    for (int s = 0; s < MAX_RES; s++) begin
      if (2'(s) < push_n) begin
        mem[wr_ptr + PW'(s)] <= {(2'(s) == push_n - 2'd1), res_byte[s]};
      end
    end
  end

`ifndef SYNTHESIS
  a_fifo_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count_next <= (PW+1)'(FIFO_DEPTH))
    else $error("result FIFO overflow");

  a_eob_flushes: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_eob |=> held_count == 2'd0)
    else $error("partial sequence kept past end of buffer");

  a_eob_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_eob |-> res_n != 2'd0)
    else $error("end of buffer item produced no result");

  a_three_held_is_four_byte: assert property (@(posedge clk) disable iff (rst)
    held_count == 2'd3 |-> held[0][7:3] == 5'b11110)
    else $error("three bytes held without a four-byte lead");

  a_pop_only_when_filled: assert property (@(posedge clk) disable iff (rst)
    count == '0 |-> !pop)
    else $error("pop from empty result FIFO");
`endif

endmodule

[tb/utf8_to_cp437_decoder_tb.sv]
// Self-checking testbench for utf8_to_cp437_decoder: a directed table, then random UTF-8 traffic.
// Expected CP437 bytes come from a local transcoder model; needs only the RTL (top and u2c_pkg).
`timescale 1ns / 1ps

module utf8_to_cp437_decoder_tb;

  localparam logic [7:0] UNMAPPED     = 8'h3F;  // '?'
  localparam int         RANDOM_ITEMS = 175;
  localparam int         STALL_LIMIT  = 1000;
  localparam int         NUM_DIRECTED = 25;

  // Unicode code points of CP437 bytes 0x80..0xFF
  localparam logic [15:0] OEM_UPPER [128] = '{
    16'h00C7, 16'h00FC, 16'h00E9, 16'h00E2, 16'h00E4, 16'h00E0, 16'h00E5, 16'h00E7,
    16'h00EA, 16'h00EB, 16'h00E8, 16'h00EF, 16'h00EE, 16'h00EC, 16'h00C4, 16'h00C5,
    16'h00C9, 16'h00E6, 16'h00C6, 16'h00F4, 16'h00F6, 16'h00F2, 16'h00FB, 16'h00F9,
    16'h00FF, 16'h00D6, 16'h00DC, 16'h00A2, 16'h00A3, 16'h00A5, 16'h20A7, 16'h0192,
    16'h00E1, 16'h00ED, 16'h00F3, 16'h00FA, 16'h00F1, 16'h00D1, 16'h00AA, 16'h00BA,
    16'h00BF, 16'h2310, 16'h00AC, 16'h00BD, 16'h00BC, 16'h00A1, 16'h00AB, 16'h00BB,
    16'h2591, 16'h2592, 16'h2593, 16'h2502, 16'h2524, 16'h2561, 16'h2562, 16'h2556,
    16'h2555, 16'h2563, 16'h2551, 16'h2557, 16'h255D, 16'h255C, 16'h255B, 16'h2510,
    16'h2514, 16'h2534, 16'h252C, 16'h251C, 16'h2500, 16'h253C, 16'h255E, 16'h255F,
    16'h255A, 16'h2554, 16'h2569, 16'h2566, 16'h2560, 16'h2550, 16'h256C, 16'h2567,
    16'h2568, 16'h2564, 16'h2565, 16'h2559, 16'h2558, 16'h2552, 16'h2553, 16'h256B,
    16'h256A, 16'h2518, 16'h250C, 16'h2588, 16'h2584, 16'h258C, 16'h2590, 16'h2580,
    16'h03B1, 16'h00DF, 16'h0393, 16'h03C0, 16'h03A3, 16'h03C3, 16'h00B5, 16'h03C4,
    16'h03A6, 16'h0398, 16'h03A9, 16'h03B4, 16'h221E, 16'h03C6, 16'h03B5, 16'h2229,
    16'h2261, 16'h00B1, 16'h2265, 16'h2264, 16'h2320, 16'h2321, 16'h00F7, 16'h2248,
    16'h00B0, 16'h2219, 16'h00B7, 16'h221A, 16'h207F, 16'h00B2, 16'h25A0, 16'h00A0
  };

  typedef struct packed {
    logic [7:0] in_byte;
    logic       eob;
    logic       typed;  // want is the whole, single-result answer
    logic [7:0] want;
  } utf8_row_t;

  localparam utf8_row_t DIRECTED [NUM_DIRECTED] = '{
    '{8'h00, 1'b0, 1'b1, 8'h00},
    '{8'h7F, 1'b0, 1'b1, 8'h7F},
    '{8'h80, 1'b0, 1'b1, UNMAPPED},  // stray continuation
    '{8'hBF, 1'b0, 1'b1, UNMAPPED},
    '{8'hF8, 1'b0, 1'b1, UNMAPPED},  // invalid leads
    '{8'hFF, 1'b0, 1'b1, UNMAPPED},
    '{8'hC3, 1'b0, 1'b0, 8'h00},
    '{8'h87, 1'b0, 1'b1, 8'h80},     // first table entry
    '{8'hC2, 1'b0, 1'b0, 8'h00},
    '{8'hA0, 1'b0, 1'b1, 8'hFF},     // last table entry
    '{8'hE2, 1'b0, 1'b0, 8'h00},
    '{8'h96, 1'b0, 1'b0, 8'h00},
    '{8'h91, 1'b0, 1'b0, 8'h00},
    '{8'hC0, 1'b0, 1'b0, 8'h00},     // overlong form passes through
    '{8'h81, 1'b0, 1'b0, 8'h00},
    '{8'hF0, 1'b0, 1'b0, 8'h00},     // four-byte, not in the table
    '{8'h90, 1'b0, 1'b0, 8'h00},
    '{8'h80, 1'b0, 1'b0, 8'h00},
    '{8'h80, 1'b0, 1'b0, 8'h00},
    '{8'hE2, 1'b0, 1'b0, 8'h00},     // truncated at end of buffer
    '{8'h94, 1'b1, 1'b0, 8'h00},
    '{8'hF0, 1'b0, 1'b0, 8'h00},     // three-result flush
    '{8'h41, 1'b0, 1'b0, 8'h00},
    '{8'h42, 1'b1, 1'b0, 8'h00},
    '{8'h41, 1'b1, 1'b1, 8'h41}
  };

  typedef struct {
    logic [7:0] ch;
    logic       tail;
  } cp437_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;  // [7:0] in_byte
  logic       s_tlast = 1'b0;   // end_of_buffer
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;          // [7:0] cp437_byte
  logic       m_tlast;          // run_last

  cp437_t     expected_cp437[$];
  int         errors = 0;
  int         stall_cycles = 0;
  bit         send_calm = 1'b0;
  bit         take_calm = 1'b0;

  // transcoder state and scratch
  logic [7:0] held_run [3];
  int         held_n = 0;
  logic [7:0] run_buf [4];
  logic [7:0] pred_code [3];
  int         pred_cnt;

  utf8_to_cp437_decoder i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int lead_len(input logic [7:0] b);
    if (b < 8'h80) return 1;
    if ((b & 8'hE0) == 8'hC0) return 2;
    if ((b & 8'hF0) == 8'hE0) return 3;
    if ((b & 8'hF8) == 8'hF0) return 4;
    return 0;
  endfunction

  function automatic logic [20:0] seq_cp(input int at, input int len);
    logic [20:0] cp;
    logic [7:0]  mask;
    int          k;
    mask = (len == 2) ? 8'h1F : (len == 3) ? 8'h0F : 8'h07;
    cp   = {13'd0, run_buf[at] & mask};
    for (k = 1; k < len; k++) cp = {cp[14:0], run_buf[at + k][5:0]};
    return cp;
  endfunction

  function automatic logic [7:0] oem_code(input logic [20:0] cp);
    int k;
    if (cp < 21'h80) return cp[7:0];
    for (k = 0; k < 128; k++)
      if (cp == {5'd0, OEM_UPPER[k]}) return 8'h80 + k[7:0];
    return UNMAPPED;
  endfunction

  function automatic logic [7:0] cont_byte();
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  // fills pred_code/pred_cnt for one accepted byte and advances the held sequence
  task automatic predict_cp437(input logic [7:0] b, input logic eob);
    int total, pos, len, k;
    pred_cnt = 0;
    for (k = 0; k < held_n; k++) run_buf[k] = held_run[k];
    run_buf[held_n] = b;
    total = held_n + 1;
    if (!eob) begin
      len = lead_len(run_buf[0]);
      if (len == 0) begin
        pred_code[0] = UNMAPPED;
        pred_cnt = 1;
        held_n = 0;
      end else if (total >= len) begin
        pred_code[0] = (len == 1) ? run_buf[0] : oem_code(seq_cp(0, len));
        pred_cnt = 1;
        held_n = 0;
      end else begin
        for (k = 0; k < total; k++) held_run[k] = run_buf[k];
        held_n = total;
      end
    end else begin
      // flush: every position is a lead, knowing how many bytes are left
      pos = 0;
      while (pos < total) begin
        len = lead_len(run_buf[pos]);
        if (len == 1) begin
          pred_code[pred_cnt] = run_buf[pos];
          pos = pos + 1;
        end else if (len >= 2 && pos + len <= total) begin
          pred_code[pred_cnt] = oem_code(seq_cp(pos, len));
          pos = pos + len;
        end else begin
          pred_code[pred_cnt] = UNMAPPED;
          pos = pos + 1;
        end
        pred_cnt = pred_cnt + 1;
      end
      held_n = 0;
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic eob, input logic typed,
                           input logic [7:0] want);
    int     gap, k;
    cp437_t e;
    if ($urandom_range(0, 15) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= eob;
    do @(posedge clk); while (!s_tready);
    predict_cp437(b, eob);
    if (typed) begin
      e.ch   = want;
      e.tail = 1'b1;
      expected_cp437 = {expected_cp437, e};
    end else begin
      for (k = 0; k < pred_cnt; k++) begin
        e.ch   = pred_code[k];
        e.tail = (k == pred_cnt - 1);
        expected_cp437 = {expected_cp437, e};
      end
    end
  endtask

  // output side: random back-pressure with calm stretches
  initial begin
    int gap;
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) take_calm = !take_calm;
      gap = take_calm ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  always @(posedge clk) begin : check_out
    cp437_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_cp437.size() == 0) begin
        errors = errors + 1;
        if (errors <= 10)
          $display("%0t: unexpected transfer: data %h last %b", $realtime, m_tdata, m_tlast);
      end else begin
        e = expected_cp437.pop_front();
        if (m_tdata !== e.ch || m_tlast !== e.tail) begin
          errors = errors + 1;
          if (errors <= 10)
            $display("%0t: mismatch: expected data %h last %b, got data %h last %b",
                     $realtime, e.ch, e.tail, m_tdata, m_tlast);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: timeout, no transfer for %0d cycles", $realtime, STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int         sent, kind, k, n, cut;
    logic [15:0] cp;
    logic [7:0]  bytes_q[$];
    logic        eob_on_last;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (k = 0; k < NUM_DIRECTED; k++)
      send_byte(DIRECTED[k].in_byte, DIRECTED[k].eob, DIRECTED[k].typed, DIRECTED[k].want);

    // random part: mostly well-formed characters, some noise and cut-off sequences
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      bytes_q.delete();
      kind = $urandom_range(0, 99);
      eob_on_last = ($urandom_range(0, 7) == 0);
      if (kind < 30) begin
        bytes_q = {bytes_q, 8'($urandom_range(0, 127))};
      end else if (kind < 55) begin
        cp = OEM_UPPER[$urandom_range(0, 127)];
        if (cp < 16'h0800) begin
          bytes_q = {bytes_q, {3'b110, cp[10:6]}};
          bytes_q = {bytes_q, {2'b10, cp[5:0]}};
        end else begin
          bytes_q = {bytes_q, {4'b1110, cp[15:12]}};
          bytes_q = {bytes_q, {2'b10, cp[11:6]}};
          bytes_q = {bytes_q, {2'b10, cp[5:0]}};
        end
      end else if (kind < 65) begin
        bytes_q = {bytes_q, 8'hC0 | 8'($urandom_range(0, 31))};
        bytes_q = {bytes_q, cont_byte()};
      end else if (kind < 75) begin
        bytes_q = {bytes_q, 8'hE0 | 8'($urandom_range(0, 15))};
        repeat (2) bytes_q = {bytes_q, cont_byte()};
      end else if (kind < 83) begin
        bytes_q = {bytes_q, 8'hF0 | 8'($urandom_range(0, 7))};
        repeat (3) bytes_q = {bytes_q, cont_byte()};
      end else if (kind < 93) begin
        bytes_q = {bytes_q, 8'($urandom_range(0, 255))};
      end else begin
        n = $urandom_range(2, 4);
        case (n)
          2:       bytes_q = {bytes_q, 8'hC0 | 8'($urandom_range(0, 31))};
          3:       bytes_q = {bytes_q, 8'hE0 | 8'($urandom_range(0, 15))};
          default: bytes_q = {bytes_q, 8'hF0 | 8'($urandom_range(0, 7))};
        endcase
        cut = $urandom_range(0, n - 2);
        repeat (cut) bytes_q = {bytes_q, cont_byte()};
        eob_on_last = 1'($urandom_range(0, 1));
      end
      for (k = 0; k < bytes_q.size(); k++) begin
        send_byte(bytes_q[k], eob_on_last && (k == bytes_q.size() - 1), 1'b0, 8'h00);
        sent = sent + 1;
      end
    end

    s_tvalid <= 1'b0;
    while (expected_cp437.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
